/* design/ppt_pkg.sv */
package ppt_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_W      = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int TOTAL_W      = 7;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int DRAIN_CYC    = 2;
  localparam int DRAIN_W      = $clog2(DRAIN_CYC + 1);

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLOSE,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } vertex_t;

  // edge from cur (a) to prev (b)
  typedef struct packed {
    logic    vld;
    vertex_t cur;
    vertex_t prev;
  } edge_req_t;

endpackage

/* design/point_in_polygon_test.sv */
// Point-in-polygon test over a stored polygon of up to MAX_VERTICES vertices.
// Each input beat carries a request kind in s_tuser (append vertex, remove last
// vertex, query point) and a 16-bit unsigned x and y in s_tdata; every beat
// gives exactly one result beat with the inside flag, an accepted flag and the
// vertex count after the request. Vertices sit in a ring of cells; a query
// rotates the ring once through a three-stage edge test (exact cross-multiply
// compare, even-odd parity) and gives its result after the scan, the closing
// edge and the pipeline drain, while appends and removes give their result on
// the cycle after accept. A new beat is taken once the block is idle and the
// result register is free or being read in the same cycle.
module point_in_polygon_test (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // coord_x, coord_y
  input  logic [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // inside_res, accepted, vertex_total, zero fill
);
  import ppt_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [CNT_W-1:0]      count;
  logic [IDX_W-1:0]      step;
  logic [DRAIN_W-1:0]    drain;
  logic [COORD_W-1:0]    px;
  logic [COORD_W-1:0]    py;
  vertex_t               first_v;
  vertex_t               prev_v;
  vertex_t               in_v;
  vertex_t               cell_v [MAX_VERTICES];
  logic                  in_fire;
  logic                  out_free;
  logic                  has_room;
  logic                  can_remove;
  logic                  load_en;
  logic                  shift;
  logic                  step_live;
  logic                  parity;
  logic                  clear;
  logic [15:0]           m_tdata_next;
  edge_req_t             edge_req;
  req_t                  req;

  assign req        = req_t'(s_tuser);
  assign in_v.x     = s_tdata[15:0];
  assign in_v.y     = s_tdata[31:16];
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == ST_IDLE) && out_free;
  assign in_fire    = s_tvalid && s_tready;
  assign has_room   = count < CNT_W'(MAX_VERTICES);
  assign can_remove = count > CNT_W'(1);
  assign load_en    = in_fire && (req == REQ_APPEND) && has_room;
  assign step_live  = {{(CNT_W-IDX_W){1'b0}}, step} < count;
  assign clear      = in_fire && (req == REQ_QUERY);

  // vertex ring, head is cell 0
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    ppt_cell u_cell (
      .clk    (clk),
      .load   (load_en && (count[IDX_W-1:0] == IDX_W'(k))),
      .shift  (shift),
      .load_v (in_v),
      .nb_v   (cell_v[(k + 1) % MAX_VERTICES]),
      .v      (cell_v[k])
    );
  end

  ppt_edge u_edge (
    .clk    (clk),
    .rst    (rst),
    .clear  (clear),
    .req    (edge_req),
    .px     (px),
    .py     (py),
    .parity (parity)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (clear) state_next = ST_SCAN;
      ST_SCAN:  if (step == IDX_W'(MAX_VERTICES - 1)) state_next = ST_CLOSE;
      ST_CLOSE: state_next = ST_DRAIN;
      ST_DRAIN: if (drain == DRAIN_W'(DRAIN_CYC - 1)) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    shift         = 1'b0;
    edge_req.vld  = 1'b0;
    edge_req.cur  = cell_v[0];
    edge_req.prev = prev_v;
    unique case (state)
      ST_SCAN: begin
        shift        = 1'b1;
        edge_req.vld = (step != '0) && step_live;
      end
      ST_CLOSE: begin
        edge_req.vld = count != '0;
        edge_req.cur = first_v;
      end
      default: begin
        shift = 1'b0;
      end
    endcase
  end

  // result beat
  always_comb begin
    m_tdata_next = m_tdata;
    if (in_fire) begin
      m_tdata_next      = '0;
      m_tdata_next[8:2] = TOTAL_W'(count);
      unique case (req)
        REQ_APPEND: begin
          m_tdata_next[1]   = has_room;
          m_tdata_next[8:2] = TOTAL_W'(has_room ? count + CNT_W'(1) : count);
        end
        REQ_REMOVE: begin
          m_tdata_next[1]   = can_remove;
          m_tdata_next[8:2] = TOTAL_W'(can_remove ? count - CNT_W'(1) : count);
        end
        default: begin
          m_tdata_next[1] = 1'b0;
        end
      endcase
    end else if (state == ST_DONE && out_free) begin
      m_tdata_next      = '0;
      m_tdata_next[0]   = parity;
      m_tdata_next[1]   = 1'b1;
      m_tdata_next[8:2] = TOTAL_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if ((in_fire && req != REQ_QUERY) || (state == ST_DONE && out_free)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (load_en) begin
        count <= count + CNT_W'(1);
      end else if (in_fire && req == REQ_REMOVE && can_remove) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // result beat and query bookkeeping
  always_ff @(posedge clk) begin
    m_tdata <= m_tdata_next;
    if (in_fire) begin
      px   <= in_v.x;
      py   <= in_v.y;
      step <= '0;
    end
    if (state == ST_SCAN) begin
      step <= step + IDX_W'(1);
      if (step == '0) begin
        first_v <= cell_v[0];
        prev_v  <= cell_v[0];
      end else if (step_live) begin
        prev_v <= cell_v[0];
      end
    end
    if (state == ST_CLOSE) begin
      drain <= '0;
    end else if (state == ST_DRAIN) begin
      drain <= drain + DRAIN_W'(1);
    end
  end

endmodule

/* design/ppt_cell.sv */
module ppt_cell (
  input  logic            clk,
  input  logic            load,
  input  logic            shift,
  input  ppt_pkg::vertex_t load_v,
  input  ppt_pkg::vertex_t nb_v,
  output ppt_pkg::vertex_t v
);
  import ppt_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      v <= load_v;
    end else if (shift) begin
      v <= nb_v;
    end
  end

endmodule

/* design/ppt_edge.sv */
module ppt_edge (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  ppt_pkg::edge_req_t           req,
  input  logic [ppt_pkg::COORD_W-1:0]  px,
  input  logic [ppt_pkg::COORD_W-1:0]  py,
  output logic                         parity
);
  import ppt_pkg::*;

  logic                     straddle;
  logic                     leftish;
  logic                     s1_vld;
  logic                     s1_dypos;
  logic signed [DIFF_W-1:0] d1;
  logic signed [DIFF_W-1:0] d2;
  logic signed [DIFF_W-1:0] d3;
  logic signed [DIFF_W-1:0] dy;
  logic                     s2_vld;
  logic                     s2_dypos;
  logic signed [PROD_W-1:0] lhs;
  logic signed [PROD_W-1:0] rhs;
  logic                     hit;

  assign straddle = (req.cur.y < py && req.prev.y >= py) ||
                    (req.prev.y < py && req.cur.y >= py);
  assign leftish  = (req.cur.x <= px) || (req.prev.x <= px);

  // stage 1: differences
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= req.vld && straddle && leftish;
    end
    s1_dypos <= req.prev.y > req.cur.y;
    d1 <= $signed({1'b0, py}) - $signed({1'b0, req.cur.y});
    d2 <= $signed({1'b0, req.prev.x}) - $signed({1'b0, req.cur.x});
    d3 <= $signed({1'b0, px}) - $signed({1'b0, req.cur.x});
    dy <= $signed({1'b0, req.prev.y}) - $signed({1'b0, req.cur.y});
  end

  // stage 2: cross products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_dypos <= s1_dypos;
    lhs      <= d1 * d2;
    rhs      <= d3 * dy;
  end

  assign hit = s2_dypos ? (lhs < rhs) : (lhs > rhs);

  // stage 3: parity
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      parity <= 1'b0;
    end else if (s2_vld && hit) begin
      parity <= ~parity;
    end
  end

endmodule
